// ===== hdl/itmb_pkg.sv =====
// Shared types and constants for the inductor trimmed-mean bias block.
package itmb_pkg;

  localparam int unsigned NumCh   = 4;
  localparam int unsigned ChW     = $clog2(NumCh);
  localparam int unsigned SampleW = 12;
  localparam int unsigned FsW     = 12;
  localparam int unsigned ClampW  = 7;
  localparam int unsigned BiasW   = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 12;

  // Shared divider: widest dividend is a 12-bit mean times 100.
  localparam int unsigned DivDW   = 19;
  localparam int unsigned DivVW   = 12;

  localparam int unsigned Pct     = 100;
  localparam int unsigned FsReset = 300;
  localparam int unsigned HiReset = 100;
  localparam int unsigned LoReset = 0;

  // Channel slots
  localparam int unsigned ChLeftOuter  = 0;
  localparam int unsigned ChRightOuter = 1;
  localparam int unsigned ChLeftInner  = 2;
  localparam int unsigned ChRightInner = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FS_LEFT_OUTER  = 3'd0,
    CFG_FS_RIGHT_OUTER = 3'd1,
    CFG_FS_LEFT_INNER  = 3'd2,
    CFG_FS_RIGHT_INNER = 3'd3,
    CFG_CLAMP_HIGH     = 3'd4,
    CFG_CLAMP_LOW      = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_NORM,
    OP_BIAS
  } div_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN,
    ST_NORM_GO,
    ST_NORM_RUN,
    ST_CLAMP,
    ST_BIAS_GO,
    ST_BIAS_RUN,
    ST_PUT
  } state_e;

  typedef struct packed {
    logic           accept;
    logic           div_start;
    div_op_e        op;
    logic [ChW-1:0] ch;
    logic           cap_mean;
    logic           cap_norm;
    logic           cap_clamp;
    logic           load_out;
  } cmd_t;

  typedef struct packed {
    logic last_round;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

// ===== hdl/itmb_div.sv =====
// Restoring divider, one quotient bit per cycle.
module itmb_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [itmb_pkg::DivDW-1:0]  dividend_i,
  input  logic [itmb_pkg::DivVW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [itmb_pkg::DivDW-1:0]  quotient_o
);

  localparam int unsigned DW   = itmb_pkg::DivDW;
  localparam int unsigned VW   = itmb_pkg::DivVW;
  localparam int unsigned CntW = $clog2(DW + 1);

  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [VW-1:0]   rem_q;
  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   dvs_q;

  logic [VW:0]     rem_sh;
  logic [VW:0]     rem_sub;
  logic            fits;

  assign rem_sh  = {rem_q, quo_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(DW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CntW'(1);
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/itmb_dp.sv =====
// Datapath: accumulators, configuration registers, shared divider and result register.
module itmb_dp #(
  parameter int unsigned ROUNDS = 5
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  itmb_pkg::cmd_t                                        cmd_i,
  output itmb_pkg::sts_t                                        sts_o,
  input  logic [itmb_pkg::NumCh-1:0][itmb_pkg::SampleW-1:0]     samples_i,
  input  logic                                                  cfg_we_i,
  input  logic [itmb_pkg::CfgIdxW-1:0]                          cfg_index_i,
  input  logic [itmb_pkg::CfgW-1:0]                             cfg_data_i,
  input  logic                                                  out_stall_i,
  output logic                                                  out_valid_o,
  output logic [itmb_pkg::ClampW-1:0]                           norm_left_outer_o,
  output logic [itmb_pkg::ClampW-1:0]                           norm_right_outer_o,
  output logic [itmb_pkg::ClampW-1:0]                           norm_left_inner_o,
  output logic [itmb_pkg::ClampW-1:0]                           norm_right_inner_o,
  output logic [itmb_pkg::ClampW-1:0]                           norm_middle_o,
  output logic signed [itmb_pkg::BiasW-1:0]                     bias_o,
  output logic signed [itmb_pkg::BiasW-1:0]                     steer_error_o,
  output logic                                                  zero_sum_o
);

  localparam int unsigned NumCh = itmb_pkg::NumCh;
  localparam int unsigned SW    = itmb_pkg::SampleW;
  localparam int unsigned CW    = itmb_pkg::ClampW;
  localparam int unsigned DW    = itmb_pkg::DivDW;
  localparam int unsigned VW    = itmb_pkg::DivVW;
  localparam int unsigned BW    = itmb_pkg::BiasW;
  localparam int unsigned RcW   = $clog2(ROUNDS);
  localparam int unsigned SumW  = $clog2(ROUNDS) + SW;

  // Trimmed mean by reciprocal multiply: rest < 2**SumW and the divisor is
  // below 16, so a ceiling reciprocal with four extra fraction bits is exact.
  localparam int unsigned MeanDiv = ROUNDS - 2;
  localparam int unsigned RecipS  = SumW + 4;
  localparam int unsigned RecipW  = RecipS + 1;
  localparam int unsigned Recip   = ((1 << RecipS) + MeanDiv - 1) / MeanDiv;
  localparam int unsigned ProdW   = SumW + RecipW;

  function automatic logic [CW-1:0] clamp_fn(input logic [DW:0] v,
                                             input logic [CW-1:0] hi,
                                             input logic [CW-1:0] lo);
    logic [CW-1:0] r;
    if (v >= (DW+1)'(hi)) begin
      r = hi;
    end else if (v <= (DW+1)'(lo)) begin
      r = lo;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [itmb_pkg::FsW-1:0] fs_q [NumCh];
  logic [CW-1:0]            hi_q;
  logic [CW-1:0]            lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) begin
        fs_q[i] <= itmb_pkg::FsW'(itmb_pkg::FsReset);
      end
      hi_q <= CW'(itmb_pkg::HiReset);
      lo_q <= CW'(itmb_pkg::LoReset);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        itmb_pkg::CFG_FS_LEFT_OUTER:  fs_q[itmb_pkg::ChLeftOuter]  <= cfg_data_i;
        itmb_pkg::CFG_FS_RIGHT_OUTER: fs_q[itmb_pkg::ChRightOuter] <= cfg_data_i;
        itmb_pkg::CFG_FS_LEFT_INNER:  fs_q[itmb_pkg::ChLeftInner]  <= cfg_data_i;
        itmb_pkg::CFG_FS_RIGHT_INNER: fs_q[itmb_pkg::ChRightInner] <= cfg_data_i;
        itmb_pkg::CFG_CLAMP_HIGH:     hi_q <= cfg_data_i[CW-1:0];
        itmb_pkg::CFG_CLAMP_LOW:      lo_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // round accumulation
  logic [RcW-1:0]  rc_q;
  logic            first_round;
  logic            last_round;
  logic [SumW-1:0] sum_q [NumCh];
  logic [SW-1:0]   max_q [NumCh];
  logic [SW-1:0]   min_q [NumCh];

  assign first_round = (rc_q == '0);
  assign last_round  = (rc_q == RcW'(ROUNDS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= '0;
    end else if (cmd_i.accept) begin
      rc_q <= last_round ? '0 : rc_q + RcW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int i = 0; i < NumCh; i++) begin
        if (first_round) begin
          sum_q[i] <= SumW'(samples_i[i]);
          max_q[i] <= samples_i[i];
          min_q[i] <= samples_i[i];
        end else begin
          sum_q[i] <= sum_q[i] + SumW'(samples_i[i]);
          if (samples_i[i] > max_q[i]) max_q[i] <= samples_i[i];
          if (samples_i[i] < min_q[i]) min_q[i] <= samples_i[i];
        end
      end
    end
  end

  // divider operands
  logic [SW:0]      trim;
  logic [SumW-1:0]  sum_sel;
  logic [SumW-1:0]  rest;
  logic [ProdW-1:0] mean_prod;
  logic [SW-1:0]    mean_q [NumCh];
  logic [DW-1:0]    norm_q [NumCh];
  logic [VW-1:0]    fs_sel;
  logic [CW-1:0]    cl_q [NumCh];
  logic [CW-1:0]    mid_q;
  logic [CW:0]      lsum;
  logic [CW:0]      rsum;
  logic [CW+1:0]    total;
  logic             neg;
  logic [CW:0]      diff;

  logic            div_done;
  logic [DW-1:0]   quotient;
  logic [DW-1:0]   dividend;
  logic [VW-1:0]   divisor;

  assign sum_sel   = sum_q[cmd_i.ch];
  assign trim      = {1'b0, max_q[cmd_i.ch]} + {1'b0, min_q[cmd_i.ch]};
  assign rest      = (sum_sel >= SumW'(trim)) ? sum_sel - SumW'(trim) : '0;
  assign mean_prod = ProdW'(rest) * ProdW'(Recip);
  assign fs_sel    = (fs_q[cmd_i.ch] == '0) ? VW'(1) : VW'(fs_q[cmd_i.ch]);

  assign lsum  = {1'b0, cl_q[itmb_pkg::ChLeftOuter]} + {1'b0, cl_q[itmb_pkg::ChLeftInner]};
  assign rsum  = {1'b0, cl_q[itmb_pkg::ChRightOuter]} + {1'b0, cl_q[itmb_pkg::ChRightInner]};
  assign total = {1'b0, lsum} + {1'b0, rsum};
  assign neg   = lsum < rsum;
  assign diff  = neg ? rsum - lsum : lsum - rsum;

  always_comb begin
    unique case (cmd_i.op)
      itmb_pkg::OP_NORM: begin
        dividend = DW'(mean_q[cmd_i.ch]) * DW'(itmb_pkg::Pct);
        divisor  = fs_sel;
      end
      itmb_pkg::OP_BIAS: begin
        dividend = DW'(diff) * DW'(itmb_pkg::Pct);
        divisor  = VW'(total);
      end
    endcase
  end

  itmb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_mean) mean_q[cmd_i.ch] <= mean_prod[RecipS +: SW];
    if (cmd_i.cap_norm) norm_q[cmd_i.ch] <= quotient;
    if (cmd_i.cap_clamp) begin
      for (int i = 0; i < NumCh; i++) begin
        cl_q[i] <= clamp_fn({1'b0, norm_q[i]}, hi_q, lo_q);
      end
      // middle value uses the inner values before clamping
      mid_q <= clamp_fn({1'b0, norm_q[itmb_pkg::ChLeftInner]}
                        + {1'b0, norm_q[itmb_pkg::ChRightInner]}, hi_q, lo_q);
    end
  end

  // result register
  logic          out_valid_q;
  logic          zero_sum;
  logic [BW-1:0] two_t;
  logic [BW-1:0] neg_two_t;

  assign zero_sum  = (total == '0);
  assign two_t     = zero_sum ? '0 : {1'b0, quotient[CW-1:0], 1'b0};
  assign neg_two_t = BW'(0) - two_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      norm_left_outer_o  <= cl_q[itmb_pkg::ChLeftOuter];
      norm_right_outer_o <= cl_q[itmb_pkg::ChRightOuter];
      norm_left_inner_o  <= cl_q[itmb_pkg::ChLeftInner];
      norm_right_inner_o <= cl_q[itmb_pkg::ChRightInner];
      norm_middle_o      <= mid_q;
      bias_o             <= neg ? neg_two_t : two_t;
      steer_error_o      <= neg ? two_t : neg_two_t;
      zero_sum_o         <= zero_sum;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.last_round = last_round;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_busy   = out_valid_q && out_stall_i;

endmodule

// ===== hdl/itmb_ctrl.sv =====
// Controller: sequences accumulation, the means, the five divisions and the result transfer.
module itmb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  itmb_pkg::sts_t sts_i,
  output itmb_pkg::cmd_t cmd_o
);

  localparam int unsigned ChW = itmb_pkg::ChW;

  itmb_pkg::state_e state_q, state_d;
  logic [ChW-1:0]   ch_q, ch_d;
  logic             last_ch;

  assign last_ch = (ch_q == ChW'(itmb_pkg::NumCh - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itmb_pkg::ST_IDLE;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    unique case (state_q)
      itmb_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.last_round) begin
          state_d = itmb_pkg::ST_MEAN;
          ch_d    = '0;
        end
      end
      itmb_pkg::ST_MEAN: begin
        ch_d    = last_ch ? '0 : ch_q + ChW'(1);
        state_d = last_ch ? itmb_pkg::ST_NORM_GO : itmb_pkg::ST_MEAN;
      end
      itmb_pkg::ST_NORM_GO: state_d = itmb_pkg::ST_NORM_RUN;
      itmb_pkg::ST_NORM_RUN: begin
        if (sts_i.div_done) begin
          ch_d    = last_ch ? '0 : ch_q + ChW'(1);
          state_d = last_ch ? itmb_pkg::ST_CLAMP : itmb_pkg::ST_NORM_GO;
        end
      end
      itmb_pkg::ST_CLAMP:   state_d = itmb_pkg::ST_BIAS_GO;
      itmb_pkg::ST_BIAS_GO: state_d = itmb_pkg::ST_BIAS_RUN;
      itmb_pkg::ST_BIAS_RUN: begin
        if (sts_i.div_done) state_d = itmb_pkg::ST_PUT;
      end
      itmb_pkg::ST_PUT: begin
        // hold until the result register is free or drains this cycle
        if (!sts_i.out_busy) state_d = itmb_pkg::ST_IDLE;
      end
      default: state_d = itmb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = itmb_pkg::OP_NORM;
    cmd_o.ch   = ch_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      itmb_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      itmb_pkg::ST_MEAN: begin
        cmd_o.cap_mean = 1'b1;
      end
      itmb_pkg::ST_NORM_GO: begin
        cmd_o.op        = itmb_pkg::OP_NORM;
        cmd_o.div_start = 1'b1;
      end
      itmb_pkg::ST_NORM_RUN: begin
        cmd_o.op       = itmb_pkg::OP_NORM;
        cmd_o.cap_norm = sts_i.div_done;
      end
      itmb_pkg::ST_CLAMP: begin
        cmd_o.cap_clamp = 1'b1;
      end
      itmb_pkg::ST_BIAS_GO: begin
        cmd_o.op        = itmb_pkg::OP_BIAS;
        cmd_o.div_start = 1'b1;
      end
      itmb_pkg::ST_BIAS_RUN: begin
        cmd_o.op = itmb_pkg::OP_BIAS;
      end
      itmb_pkg::ST_PUT: begin
        cmd_o.op       = itmb_pkg::OP_BIAS;
        cmd_o.load_out = !sts_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/inductor_trimmed_mean_bias.sv =====
// Top level of the inductor trimmed-mean bias block.
//
//  channel | direction  | handshake               | payload
//  --------+------------+-------------------------+--------------------------------------------
//  in      | to block   | in_valid_i/in_stall_o   | four 12-bit samples, one round per transfer
//  out     | from block | out_valid_o/out_stall_i | five 7-bit values, bias, steer error, flag
//  cfg     | to block   | cfg_valid_i/cfg_ready_o | 3-bit register index, 12-bit data
//
// A round that is not the last of a batch is only accumulated, and the block stays ready. The last
// round is accepted, then the trimmed means of the four channels are formed in turn (reciprocal
// multiply), five divisions run through one 19-bit restoring divider: four scalings, a clamp, then
// one ratio and, once the result register is free, its load before the next round is taken.
// Reset clears the round count, the controller and the result valid; configuration
// registers return to their defaults. A stalled result is held while new rounds accumulate.
module inductor_trimmed_mean_bias #(
  parameter int unsigned ROUNDS = 5
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [itmb_pkg::SampleW-1:0]          sample_left_outer_i,
  input  logic [itmb_pkg::SampleW-1:0]          sample_right_outer_i,
  input  logic [itmb_pkg::SampleW-1:0]          sample_left_inner_i,
  input  logic [itmb_pkg::SampleW-1:0]          sample_right_inner_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [itmb_pkg::ClampW-1:0]           norm_left_outer_o,
  output logic [itmb_pkg::ClampW-1:0]           norm_right_outer_o,
  output logic [itmb_pkg::ClampW-1:0]           norm_left_inner_o,
  output logic [itmb_pkg::ClampW-1:0]           norm_right_inner_o,
  output logic [itmb_pkg::ClampW-1:0]           norm_middle_o,
  output logic signed [itmb_pkg::BiasW-1:0]     bias_o,
  output logic signed [itmb_pkg::BiasW-1:0]     steer_error_o,
  output logic                                  zero_sum_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [itmb_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [itmb_pkg::CfgW-1:0]             cfg_data_i
);

  itmb_pkg::cmd_t cmd;
  itmb_pkg::sts_t sts;
  logic [itmb_pkg::NumCh-1:0][itmb_pkg::SampleW-1:0] samples;

  assign samples[itmb_pkg::ChLeftOuter]  = sample_left_outer_i;
  assign samples[itmb_pkg::ChRightOuter] = sample_right_outer_i;
  assign samples[itmb_pkg::ChLeftInner]  = sample_left_inner_i;
  assign samples[itmb_pkg::ChRightInner] = sample_right_inner_i;

  // the user must write registers only while idle; the block does not enforce it, so always take the transfer
  assign cfg_ready_o = 1'b1;

  itmb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itmb_dp #(
    .ROUNDS (ROUNDS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .samples_i          (samples),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .norm_left_outer_o  (norm_left_outer_o),
    .norm_right_outer_o (norm_right_outer_o),
    .norm_left_inner_o  (norm_left_inner_o),
    .norm_right_inner_o (norm_right_inner_o),
    .norm_middle_o      (norm_middle_o),
    .bias_o             (bias_o),
    .steer_error_o      (steer_error_o),
    .zero_sum_o         (zero_sum_o)
  );

endmodule

// ===== dv/tb_inductor_trimmed_mean_bias.sv =====
// Self-checking testbench for the inductor trimmed-mean bias block.
module tb_inductor_trimmed_mean_bias;
  timeunit 1ns;
  timeprecision 1ps;

  import itmb_pkg::*;

  localparam int unsigned Rounds       = 5;
  localparam int unsigned SettleCycles = 250;
  localparam int unsigned HoldCycles   = 800;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned BatchesPer   = 25;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PressurePh   = 6;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;

  typedef struct packed {
    logic [SampleW-1:0] left_outer;
    logic [SampleW-1:0] right_outer;
    logic [SampleW-1:0] left_inner;
    logic [SampleW-1:0] right_inner;
  } adc_round_t;

  typedef struct packed {
    logic [ClampW-1:0] left_outer;
    logic [ClampW-1:0] right_outer;
    logic [ClampW-1:0] left_inner;
    logic [ClampW-1:0] right_inner;
    logic [ClampW-1:0] middle;
    logic [BiasW-1:0]  bias;
    logic [BiasW-1:0]  steer;
    logic              zero;
  } steer_frame_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [SampleW-1:0]  sample_left_outer_i = '0;
  logic [SampleW-1:0]  sample_right_outer_i = '0;
  logic [SampleW-1:0]  sample_left_inner_i = '0;
  logic [SampleW-1:0]  sample_right_inner_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ClampW-1:0]   norm_left_outer_o;
  logic [ClampW-1:0]   norm_right_outer_o;
  logic [ClampW-1:0]   norm_left_inner_o;
  logic [ClampW-1:0]   norm_right_inner_o;
  logic [ClampW-1:0]   norm_middle_o;
  logic signed [BiasW-1:0] bias_o;
  logic signed [BiasW-1:0] steer_error_o;
  logic                zero_sum_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;

  inductor_trimmed_mean_bias #(.ROUNDS(Rounds)) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .sample_left_outer_i (sample_left_outer_i),
    .sample_right_outer_i(sample_right_outer_i),
    .sample_left_inner_i (sample_left_inner_i),
    .sample_right_inner_i(sample_right_inner_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .norm_left_outer_o   (norm_left_outer_o),
    .norm_right_outer_o  (norm_right_outer_o),
    .norm_left_inner_o   (norm_left_inner_o),
    .norm_right_inner_o  (norm_right_inner_o),
    .norm_middle_o       (norm_middle_o),
    .bias_o              (bias_o),
    .steer_error_o       (steer_error_o),
    .zero_sum_o          (zero_sum_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: register copies and per-channel accumulators.
  logic [FsW-1:0]     fs_reg [NumCh];
  logic [ClampW-1:0]  hi_reg;
  logic [ClampW-1:0]  lo_reg;
  logic [3:0]         rounds_in;
  logic [15:0]        acc_sum [NumCh];
  logic [SampleW-1:0] acc_max [NumCh];
  logic [SampleW-1:0] acc_min [NumCh];

  adc_round_t   rounds_todo [$];
  steer_frame_t frames_due [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_armed = 1'b0;
  bit          hold_spent = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;
  int unsigned fails = 0;
  int unsigned rounds_taken = 0;
  int unsigned frames_checked = 0;
  int unsigned cfg_writes = 0;
  adc_round_t  next_round;
  steer_frame_t got_frame;

  function automatic void reset_model();
    int ch;
    for (ch = 0; ch < NumCh; ch++) begin
      fs_reg[ch]  = FsW'(FsReset);
      acc_sum[ch] = '0;
      acc_max[ch] = '0;
      acc_min[ch] = '0;
    end
    hi_reg    = ClampW'(HiReset);
    lo_reg    = ClampW'(LoReset);
    rounds_in = '0;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    case (idx)
      CFG_FS_LEFT_OUTER:  fs_reg[ChLeftOuter]  = val;
      CFG_FS_RIGHT_OUTER: fs_reg[ChRightOuter] = val;
      CFG_FS_LEFT_INNER:  fs_reg[ChLeftInner]  = val;
      CFG_FS_RIGHT_INNER: fs_reg[ChRightInner] = val;
      CFG_CLAMP_HIGH:     hi_reg = val[ClampW-1:0];
      CFG_CLAMP_LOW:      lo_reg = val[ClampW-1:0];
      default: ;
    endcase
  endfunction

  // High bound wins over low bound when they cross.
  function automatic int unsigned clip(input int unsigned v);
    if (v >= hi_reg) return hi_reg;
    if (v <= lo_reg) return lo_reg;
    return v;
  endfunction

  function automatic void fold_round(input adc_round_t r);
    logic [SampleW-1:0] s [NumCh];
    int unsigned norm [NumCh];
    int unsigned trim, rest, mean, div, mid, lsum, rsum, total, mag;
    bit neg;
    int ch;
    steer_frame_t f;
    s[ChLeftOuter]  = r.left_outer;
    s[ChRightOuter] = r.right_outer;
    s[ChLeftInner]  = r.left_inner;
    s[ChRightInner] = r.right_inner;
    for (ch = 0; ch < NumCh; ch++) begin
      if (rounds_in == 0) begin
        acc_sum[ch] = 16'(s[ch]);
        acc_max[ch] = s[ch];
        acc_min[ch] = s[ch];
      end else begin
        acc_sum[ch] = acc_sum[ch] + 16'(s[ch]);
        if (s[ch] > acc_max[ch]) acc_max[ch] = s[ch];
        if (s[ch] < acc_min[ch]) acc_min[ch] = s[ch];
      end
    end
    rounds_in = rounds_in + 4'd1;
    if (rounds_in < Rounds) return;
    rounds_in = '0;

    for (ch = 0; ch < NumCh; ch++) begin
      trim = acc_max[ch] + acc_min[ch];
      rest = (acc_sum[ch] >= trim) ? acc_sum[ch] - trim : 0;
      mean = rest / (Rounds - 2);
      div  = (fs_reg[ch] == 0) ? 1 : fs_reg[ch];
      norm[ch] = (mean * Pct) / div;
    end
    mid = clip(norm[ChLeftInner] + norm[ChRightInner]);
    for (ch = 0; ch < NumCh; ch++) norm[ch] = clip(norm[ch]);

    lsum  = norm[ChLeftOuter] + norm[ChLeftInner];
    rsum  = norm[ChRightOuter] + norm[ChRightInner];
    total = lsum + rsum;
    mag   = 0;
    neg   = 1'b0;
    if (total != 0) begin
      if (lsum >= rsum) begin
        mag = ((lsum - rsum) * Pct) / total;
      end else begin
        mag = ((rsum - lsum) * Pct) / total;
        neg = 1'b1;
      end
    end

    f.left_outer  = ClampW'(norm[ChLeftOuter]);
    f.right_outer = ClampW'(norm[ChRightOuter]);
    f.left_inner  = ClampW'(norm[ChLeftInner]);
    f.right_inner = ClampW'(norm[ChRightInner]);
    f.middle      = ClampW'(mid);
    f.bias        = neg ? BiasW'(0 - 2 * mag) : BiasW'(2 * mag);
    f.steer       = neg ? BiasW'(2 * mag) : BiasW'(0 - 2 * mag);
    f.zero        = (total == 0);
    frames_due.push_back(f);
  endfunction

  task automatic cmp_field(input string what, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // Input driver: predict on each transfer, then offer the next pending round.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        fold_round({sample_left_outer_i, sample_right_outer_i,
                    sample_left_inner_i, sample_right_inner_i});
        rounds_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (rounds_todo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_round = rounds_todo.pop_front();
          in_valid_i <= 1'b1;
          sample_left_outer_i  <= next_round.left_outer;
          sample_right_outer_i <= next_round.right_outer;
          sample_left_inner_i  <= next_round.left_inner;
          sample_right_inner_i <= next_round.right_inner;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          fails++;
          $display("%0t ns: result with nothing expected, actual bias %h", $time, bias_o);
        end else begin
          got_frame = frames_due.pop_front();
          cmp_field("norm_left_outer", 9'(got_frame.left_outer), 9'(norm_left_outer_o));
          cmp_field("norm_right_outer", 9'(got_frame.right_outer), 9'(norm_right_outer_o));
          cmp_field("norm_left_inner", 9'(got_frame.left_inner), 9'(norm_left_inner_o));
          cmp_field("norm_right_inner", 9'(got_frame.right_inner), 9'(norm_right_inner_o));
          cmp_field("norm_middle", 9'(got_frame.middle), 9'(norm_middle_o));
          cmp_field("bias", got_frame.bias, bias_o);
          cmp_field("steer_error", got_frame.steer, steer_error_o);
          cmp_field("zero_sum", 9'(got_frame.zero), 9'(zero_sum_o));
          frames_checked++;
        end
      end
      if (hold_armed && !hold_spent) begin
        hold_left  <= HoldCycles;
        hold_spent <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("watchdog: no transfer for %0d cycles at %0t ns", quiet, $time);
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Leaves cfg_valid_i high; the caller lowers it after the last write.
  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    apply_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic load_setup(input logic [FsW-1:0] fs_lo, input logic [FsW-1:0] fs_ro,
                            input logic [FsW-1:0] fs_li, input logic [FsW-1:0] fs_ri,
                            input logic [ClampW-1:0] hi, input logic [ClampW-1:0] lo);
    put_reg(CFG_FS_LEFT_OUTER, fs_lo);
    put_reg(CFG_FS_RIGHT_OUTER, fs_ro);
    put_reg(CFG_FS_LEFT_INNER, fs_li);
    put_reg(CFG_FS_RIGHT_INNER, fs_ri);
    put_reg(CFG_CLAMP_HIGH, CfgW'(hi));
    put_reg(CFG_CLAMP_LOW, CfgW'(lo));
  endtask

  function automatic logic [FsW-1:0] pick_fs();
    if ($urandom_range(0, 99) < 80) return FsW'($urandom_range(1, 600));
    return FsW'($urandom_range(1, 4095));
  endfunction

  function automatic logic [SampleW-1:0] near(input int unsigned base);
    int v;
    if ($urandom_range(0, 9) == 0) return SampleW'($urandom_range(0, 4095));
    v = int'(base) + int'($urandom_range(0, 60)) - 30;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SampleW'(v);
  endfunction

  // One batch of rounds around a level per channel, with occasional spikes.
  task automatic queue_batch();
    int unsigned lvl [NumCh];
    int ch, k;
    adc_round_t r;
    for (ch = 0; ch < NumCh; ch++) begin
      case ($urandom_range(0, 9))
        0, 1:    lvl[ch] = 0;
        2, 3, 4: lvl[ch] = $urandom_range(0, 4095);
        default: lvl[ch] = $urandom_range(0, 600);
      endcase
    end
    for (k = 0; k < Rounds; k++) begin
      r.left_outer  = near(lvl[ChLeftOuter]);
      r.right_outer = near(lvl[ChRightOuter]);
      r.left_inner  = near(lvl[ChLeftInner]);
      r.right_inner = near(lvl[ChRightInner]);
      rounds_todo.push_back(r);
    end
  endtask

  task automatic settle();
    while (rounds_todo.size() != 0 || in_valid_i || frames_due.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned ph, b, k;
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed batches with reset settings: zero sum, full scale, left-only,
    // right-only, then trimming of spikes with alternating bit patterns.
    send_idle_pct = 21;
    recv_idle_pct = 49;
    @(negedge clk_i);
    for (k = 0; k < Rounds; k++) rounds_todo.push_back('{12'd0, 12'd0, 12'd0, 12'd0});
    for (k = 0; k < Rounds; k++)
      rounds_todo.push_back('{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
    for (k = 0; k < Rounds; k++) rounds_todo.push_back('{12'hFFF, 12'd0, 12'hFFF, 12'd0});
    for (k = 0; k < Rounds; k++) rounds_todo.push_back('{12'd0, 12'hFFF, 12'd0, 12'hFFF});
    rounds_todo.push_back('{12'd100, 12'hAAA, 12'd50, 12'd200});
    rounds_todo.push_back('{12'hFFF, 12'h555, 12'd60, 12'd0});
    rounds_todo.push_back('{12'd0, 12'd300, 12'hFFF, 12'd210});
    rounds_todo.push_back('{12'd200, 12'd310, 12'd40, 12'hFFF});
    rounds_todo.push_back('{12'd300, 12'd320, 12'd70, 12'd220});
    settle();

    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: load_setup(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 7'd100, 7'd0);
        1: load_setup(12'd1, 12'd1, 12'd1, 12'd1, 7'd100, 7'd0);
        // zero full scale behaves as one
        2: load_setup(12'd0, pick_fs(), 12'd0, pick_fs(), 7'd60, 7'd10);
        // crossed bounds
        3: load_setup(pick_fs(), pick_fs(), pick_fs(), pick_fs(), 7'd20, 7'd80);
        4: load_setup(pick_fs(), pick_fs(), pick_fs(), pick_fs(), 7'd0, 7'd0);
        5: load_setup(pick_fs(), pick_fs(), pick_fs(), pick_fs(),
                      ClampW'($urandom_range(0, 100)), ClampW'($urandom_range(0, 100)));
        6: begin
          load_setup(pick_fs(), pick_fs(), pick_fs(), pick_fs(),
                     ClampW'($urandom_range(50, 100)), ClampW'($urandom_range(0, 30)));
          put_reg(CfgSpareA, CfgW'($urandom_range(0, 4095)));
          put_reg(CfgSpareB, CfgW'($urandom_range(0, 4095)));
        end
        default: load_setup(FsW'(FsReset), FsW'(FsReset), FsW'(FsReset), FsW'(FsReset),
                            ClampW'(HiReset), ClampW'(LoReset));
      endcase
      cfg_valid_i <= 1'b0;
      if (ph < 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 49;
      end else if (ph < 6) begin
        send_idle_pct = 49;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      @(negedge clk_i);
      if (ph == PressurePh) hold_armed = 1'b1;
      for (b = 0; b < BatchesPer; b++) queue_batch();
      settle();
    end

    $display("covered %0d rounds and %0d checked results over %0d register writes,",
             rounds_taken, frames_checked, cfg_writes);
    $display("with min, max and zero full scale, crossed bounds and a long output stall");
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fails);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
